### hdl/rpb_pkg.sv
package rpb_pkg;

    localparam int ROWS_PER_BAND = 8;
    localparam int MAX_WIDTH     = 240;
    localparam int PALETTE_DEPTH = 256;

    typedef enum logic [1:0] {
        OP_RUN   = 2'd0,
        OP_PAL   = 2'd1,
        OP_FRAME = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] REG_BOX_WIDTH = 3'd2;
    localparam logic [2:0] REG_BOX_BANDS = 3'd3;
    localparam logic [2:0] REG_SURROUND  = 3'd4;

    typedef struct packed {
        logic [7:0]  box_width;
        logic [4:0]  box_bands;
        logic [15:0] surround_colour;
    } frame_cfg_t;

    typedef struct packed {
        logic busy;
        logic frame_over;
    } seg_status_t;

    typedef struct packed {
        logic [10:0] band_offset;
        logic [7:0]  pixel_count;
        logic [15:0] pixel_colour;
        logic        see_through;
        logic [7:0]  band_row;
        logic        band_ready;
        logic        frame_done;
        logic        last_of_run;
    } seg_t;

endpackage

### hdl/rle_palette_band_renderer_top.sv
// Decodes (length, palette index) run items into fill segments for 8-row bands of a
// cropped box. Op 1 items load the 256-entry RGB565 palette, op 2 items start a frame
// and sample box_width, box_bands and surround_colour. A run item first reads its colour
// from the palette memory and then emits one segment for each band that it touches, each
// waiting while the output is stalled; the palette read and the segment loop are the
// limiting parts. Segments leave through an output register, so the next item is taken
// while the last segment waits. Index 0 yields see-through segments in the surround colour;
// pixels past the end of the frame are dropped.
module rle_palette_band_renderer_top
    import rpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  run_length,
    input  logic [7:0]  colour_index,
    input  logic [15:0] palette_word,
    output logic        seg_valid,
    input  logic        seg_stall,
    output logic [10:0] band_offset,
    output logic [7:0]  pixel_count,
    output logic [15:0] pixel_colour,
    output logic        see_through,
    output logic [7:0]  band_row,
    output logic        band_ready,
    output logic        frame_done,
    output logic        last_of_run
);

    logic [7:0]  origin_x_reg;
    logic [7:0]  origin_y_reg;
    logic [7:0]  box_width_reg;
    logic [4:0]  box_bands_reg;
    logic [15:0] surround_reg;
    logic        cfg_write;
    logic [2:0]  reg_index;
    logic        accept;
    logic [15:0] ram_rdata;
    frame_cfg_t  cfg;
    seg_status_t status;
    seg_t        seg;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= 8'd0;
            origin_y_reg <= 8'd0;
            box_width_reg <= 8'(MAX_WIDTH);
            box_bands_reg <= 5'd30;
            surround_reg <= 16'hFFFF;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_ORIGIN_X:  origin_x_reg <= pwdata[7:0];
                REG_ORIGIN_Y:  origin_y_reg <= pwdata[7:0];
                REG_BOX_WIDTH: box_width_reg <= pwdata[7:0];
                REG_BOX_BANDS: box_bands_reg <= pwdata[4:0];
                REG_SURROUND:  surround_reg <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_ORIGIN_X:  prdata = {24'd0, origin_x_reg};
            REG_ORIGIN_Y:  prdata = {24'd0, origin_y_reg};
            REG_BOX_WIDTH: prdata = {24'd0, box_width_reg};
            REG_BOX_BANDS: prdata = {27'd0, box_bands_reg};
            REG_SURROUND:  prdata = {16'd0, surround_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.box_width = box_width_reg;
    assign cfg.box_bands = box_bands_reg;
    assign cfg.surround_colour = surround_reg;

    assign item_stall = status.busy;
    assign accept = item_valid && !item_stall;

    rpb_palette_ram u_palette (
        .clk   (clk),
        .we    (accept && (op == OP_PAL)),
        .waddr (colour_index),
        .wdata (palette_word),
        .re    (accept && (op == OP_RUN)),
        .raddr (colour_index),
        .rdata (ram_rdata)
    );

    rpb_segmenter u_segmenter (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .op           (op),
        .run_length   (run_length),
        .colour_index (colour_index),
        .cfg          (cfg),
        .ram_rdata    (ram_rdata),
        .seg_stall    (seg_stall),
        .seg_valid    (seg_valid),
        .seg          (seg),
        .status       (status)
    );

    assign band_offset = seg.band_offset;
    assign pixel_count = seg.pixel_count;
    assign pixel_colour = seg.pixel_colour;
    assign see_through = seg.see_through;
    assign band_row = seg.band_row;
    assign band_ready = seg.band_ready;
    assign frame_done = seg.frame_done;
    assign last_of_run = seg.last_of_run;

    // The frame always ends on a band boundary, and nothing follows it in the run.
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && frame_done |-> band_ready && last_of_run)
        else $error("frame end without band end or last segment");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid |-> pixel_count != 8'd0)
        else $error("empty segment delivered");

    // A live run holds off the next item for at least its palette read.
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == OP_RUN) && (run_length != 8'd0) && !status.frame_over
        |=> item_stall)
        else $error("item taken while a run is being split");

endmodule

### hdl/rpb_palette_ram.sv
module rpb_palette_ram
    import rpb_pkg::*;
(
    input  logic        clk,
    input  logic        we,
    input  logic [7:0]  waddr,
    input  logic [15:0] wdata,
    input  logic        re,
    input  logic [7:0]  raddr,
    output logic [15:0] rdata
);

    logic [15:0] mem [PALETTE_DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/rpb_segmenter.sv
module rpb_segmenter
    import rpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [1:0]  op,
    input  logic [7:0]  run_length,
    input  logic [7:0]  colour_index,
    input  frame_cfg_t  cfg,
    input  logic [15:0] ram_rdata,
    input  logic        seg_stall,
    output logic        seg_valid,
    output seg_t        seg,
    output seg_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic        field_reg, field_next;
    logic [10:0] band_pos_reg, band_pos_next;
    logic [15:0] pixels_done_reg, pixels_done_next;
    logic [7:0]  row_reg, row_next;
    logic        frame_over_reg, frame_over_next;
    logic [10:0] band_pixels_reg, band_pixels_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] surround_reg, surround_next;
    logic        out_valid_reg, out_valid_next;
    seg_t        out_reg;
    seg_t        seg_new;

    logic [7:0]  width_sat;
    logic [10:0] start_band_pixels;
    logic [15:0] start_total;
    logic [10:0] space;
    logic [15:0] left;
    logic [7:0]  n_space;
    logic [7:0]  n;
    logic [10:0] pos_sum;
    logic [15:0] done_sum;
    logic [7:0]  rem_after;
    logic        seg_ready;
    logic        seg_done;
    logic        emit_go;
    logic        run_go;

    // Frame geometry, latched when a frame starts.
    always_comb
    begin
        width_sat = (cfg.box_width > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : cfg.box_width;
        start_band_pixels = 11'(32'(width_sat) * ROWS_PER_BAND);
        start_total = 16'(start_band_pixels) * 16'(cfg.box_bands);
    end

    // One segment: clipped by the run, the band and the frame.
    always_comb
    begin
        space = band_pixels_reg - band_pos_reg;
        left = total_reg - pixels_done_reg;
        n_space = (11'(remaining_reg) < space) ? remaining_reg : space[7:0];
        n = (16'(n_space) > left) ? left[7:0] : n_space;
        pos_sum = band_pos_reg + 11'(n);
        done_sum = pixels_done_reg + 16'(n);
        rem_after = remaining_reg - n;
        seg_ready = (pos_sum >= band_pixels_reg);
        seg_done = (done_sum >= total_reg);
        seg_new.band_offset = band_pos_reg;
        seg_new.pixel_count = n;
        seg_new.pixel_colour = field_reg ? surround_reg : ram_rdata;
        seg_new.see_through = field_reg;
        seg_new.band_row = row_reg;
        seg_new.band_ready = seg_ready;
        seg_new.frame_done = seg_done;
        seg_new.last_of_run = (rem_after == 8'd0) || seg_done;
    end

    assign emit_go = (state_reg == ST_EMIT) && (!out_valid_reg || !seg_stall);
    assign run_go = accept && (op == OP_RUN) && !frame_over_reg && (run_length != 8'd0);

    always_comb
    begin
        state_next = state_reg;
        remaining_next = remaining_reg;
        field_next = field_reg;
        band_pos_next = band_pos_reg;
        pixels_done_next = pixels_done_reg;
        row_next = row_reg;
        frame_over_next = frame_over_reg;
        band_pixels_next = band_pixels_reg;
        total_next = total_reg;
        surround_next = surround_reg;
        out_valid_next = out_valid_reg && seg_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_FRAME))
                begin
                    band_pixels_next = start_band_pixels;
                    total_next = start_total;
                    surround_next = cfg.surround_colour;
                    pixels_done_next = 16'd0;
                    band_pos_next = 11'd0;
                    row_next = 8'd0;
                    frame_over_next = (width_sat == 8'd0) || (cfg.box_bands == 5'd0);
                end
                else if (run_go)
                begin
                    remaining_next = run_length;
                    field_next = (colour_index == 8'd0);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    remaining_next = rem_after;
                    pixels_done_next = done_sum;
                    if (seg_ready)
                    begin
                        band_pos_next = 11'd0;
                        row_next = row_reg + 8'(ROWS_PER_BAND);
                    end
                    else
                    begin
                        band_pos_next = pos_sum;
                    end
                    if (seg_done)
                    begin
                        frame_over_next = 1'b1;
                    end
                    if (seg_new.last_of_run)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            band_pos_reg <= 11'd0;
            pixels_done_reg <= 16'd0;
            row_reg <= 8'd0;
            frame_over_reg <= 1'b1;
            band_pixels_reg <= 11'd0;
            total_reg <= 16'd0;
            surround_reg <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            band_pos_reg <= band_pos_next;
            pixels_done_reg <= pixels_done_next;
            row_reg <= row_next;
            frame_over_reg <= frame_over_next;
            band_pixels_reg <= band_pixels_next;
            total_reg <= total_next;
            surround_reg <= surround_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        remaining_reg <= remaining_next;
        field_reg <= field_next;
        if (emit_go)
        begin
            out_reg <= seg_new;
        end
    end

    assign seg_valid = out_valid_reg;
    assign seg = out_reg;
    assign status.busy = (state_reg != ST_IDLE);
    assign status.frame_over = frame_over_reg;

endmodule

### dv/rpb_seg_model_pkg.sv
`timescale 1ns / 100ps

package rpb_seg_model_pkg;
    import rpb_pkg::*;

    // Tracks the renderer's frame state and the segments it still owes.
    class band_render_model;
        logic [15:0] palette [PALETTE_DEPTH];
        logic [7:0]  origin_x;
        logic [7:0]  origin_y;
        logic [7:0]  box_width;
        logic [4:0]  box_bands;
        logic [15:0] surround;
        int unsigned lat_width;
        int unsigned lat_bands;
        logic [15:0] lat_surround;
        int unsigned pixels_done;
        int unsigned band_pos;
        int unsigned band_top;
        bit          frame_closed;
        seg_t        segments_due [$];
        int unsigned mismatches;

        function new();
            foreach (palette[i])
                palette[i] = '0;
            origin_x     = '0;
            origin_y     = '0;
            box_width    = 8'd240;
            box_bands    = 5'd30;
            surround     = 16'hFFFF;
            lat_width    = 0;
            lat_bands    = 0;
            lat_surround = '0;
            pixels_done  = 0;
            band_pos     = 0;
            band_top     = 0;
            frame_closed = 1'b1;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_ORIGIN_X:  origin_x = value[7:0];
                REG_ORIGIN_Y:  origin_y = value[7:0];
                REG_BOX_WIDTH: box_width = value[7:0];
                REG_BOX_BANDS: box_bands = value[4:0];
                REG_SURROUND:  surround = value[15:0];
                default: ;
            endcase
        endfunction

        function void apply_item(op_t kind, logic [7:0] len, logic [7:0] idx,
                                 logic [15:0] word);
            int unsigned band_pixels;
            int unsigned total;
            int unsigned remaining;
            int unsigned n;
            logic [15:0] colour;
            seg_t        s;
            case (kind)
                OP_PAL: palette[idx] = word;
                OP_FRAME:
                begin
                    lat_width    = (box_width > MAX_WIDTH) ? MAX_WIDTH : box_width;
                    lat_bands    = box_bands;
                    lat_surround = surround;
                    pixels_done  = 0;
                    band_pos     = 0;
                    band_top     = 0;
                    frame_closed = (lat_width == 0) || (lat_bands == 0);
                end
                OP_RUN:
                begin
                    if (!frame_closed && len != 0)
                    begin
                        band_pixels = lat_width * ROWS_PER_BAND;
                        total       = band_pixels * lat_bands;
                        colour      = (idx == 0) ? lat_surround : palette[idx];
                        remaining   = len;
                        // The run is cut at each band edge and at the end of the frame.
                        while (remaining > 0 && !frame_closed)
                        begin
                            n = (remaining < band_pixels - band_pos) ?
                                remaining : band_pixels - band_pos;
                            if (n > total - pixels_done)
                                n = total - pixels_done;
                            s.band_offset  = 11'(band_pos);
                            s.pixel_count  = 8'(n);
                            s.pixel_colour = colour;
                            s.see_through  = (idx == 0);
                            s.band_row     = 8'(band_top);
                            s.band_ready   = 1'b0;
                            s.frame_done   = 1'b0;
                            band_pos      += n;
                            pixels_done   += n;
                            remaining     -= n;
                            if (band_pos >= band_pixels)
                            begin
                                s.band_ready = 1'b1;
                                band_pos     = 0;
                                band_top    += ROWS_PER_BAND;
                            end
                            if (pixels_done >= total)
                            begin
                                s.frame_done = 1'b1;
                                frame_closed = 1'b1;
                            end
                            s.last_of_run = (remaining == 0) || frame_closed;
                            segments_due.push_back(s);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                mismatches++;
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            end
        endfunction

        function void take_segment(seg_t got);
            seg_t want;
            if (segments_due.size() == 0)
            begin
                mismatches++;
                $error("segment arrived with none outstanding: offset 0x%0h count %0d",
                       got.band_offset, got.pixel_count);
                return;
            end
            want = segments_due.pop_front();
            compare_field("band_offset", 16'(want.band_offset), 16'(got.band_offset));
            compare_field("pixel_count", 16'(want.pixel_count), 16'(got.pixel_count));
            compare_field("pixel_colour", want.pixel_colour, got.pixel_colour);
            compare_field("see_through", 16'(want.see_through), 16'(got.see_through));
            compare_field("band_row", 16'(want.band_row), 16'(got.band_row));
            compare_field("band_ready", 16'(want.band_ready), 16'(got.band_ready));
            compare_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
            compare_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
        endfunction
    endclass

endpackage

### dv/tb_rle_palette_band_renderer_top.sv
`timescale 1ns / 100ps

module tb_rle_palette_band_renderer_top;
    import rpb_pkg::*;
    import rpb_seg_model_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  op;
    logic [7:0]  run_length;
    logic [7:0]  colour_index;
    logic [15:0] palette_word;
    logic        seg_valid;
    logic        seg_stall;
    logic [10:0] band_offset;
    logic [7:0]  pixel_count;
    logic [15:0] pixel_colour;
    logic        see_through;
    logic [7:0]  band_row;
    logic        band_ready;
    logic        frame_done;
    logic        last_of_run;

    band_render_model model;
    bit               written [PALETTE_DEPTH];
    int unsigned      gap_pct = 0;
    int unsigned      stall_pct = 0;
    int unsigned      cycles = 0;

    rle_palette_band_renderer_top u_top (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("rle_palette_band_renderer_top regression: fail");
            $finish;
        end
    end

    always @(negedge clk)
        seg_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && seg_valid && !seg_stall)
            model.take_segment({band_offset, pixel_count, pixel_colour, see_through,
                                band_row, band_ready, frame_done, last_of_run});
    end

    task automatic send_item(op_t kind, logic [7:0] len, logic [7:0] idx,
                             logic [15:0] word);
        int unsigned gap;
        gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 4) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid   <= 1'b1;
        op           <= kind;
        run_length   <= len;
        colour_index <= idx;
        palette_word <= word;
        do
            @(posedge clk);
        while (item_stall);
        model.apply_item(kind, len, idx, word);
        if (kind == OP_PAL)
            written[idx] = 1'b1;
    endtask

    // A run never points at a palette entry that has not been loaded.
    task automatic send_run(logic [7:0] len, logic [7:0] idx);
        if (idx != 0 && !written[idx])
            send_item(OP_PAL, 8'($urandom), idx, 16'($urandom));
        send_item(OP_RUN, len, idx, 16'($urandom));
    endtask

    task automatic send_frame();
        send_item(OP_FRAME, 8'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (model.segments_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        model.write_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_box(logic [7:0] width, logic [4:0] bands, logic [15:0] surround,
                           logic [7:0] ox, logic [7:0] oy);
        cfg_write(REG_ORIGIN_X, {24'd0, ox});
        cfg_write(REG_ORIGIN_Y, {24'd0, oy});
        cfg_write(REG_BOX_WIDTH, {24'd0, width});
        cfg_write(REG_BOX_BANDS, {27'd0, bands});
        cfg_write(REG_SURROUND, {16'd0, surround});
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned made;
        int unsigned roll;
        logic [7:0]  len;
        made = 0;
        send_frame();
        while (made < count)
        begin
            roll = $urandom_range(99);
            if (model.frame_closed && roll < 75)
            begin
                send_frame();
                made++;
            end
            else if (roll < 10)
            begin
                send_item(OP_PAL, 8'($urandom), 8'($urandom), 16'($urandom));
                made++;
            end
            else if (roll < 14)
                send_item(OP_NONE, 8'($urandom), 8'($urandom), 16'($urandom));
            else if (roll < 18)
            begin
                send_frame();
                made++;
            end
            else
            begin
                case ($urandom_range(3))
                    0: len = 8'($urandom);
                    1: len = 8'($urandom_range(1, 8));
                    2: len = 8'($urandom_range(1, 40));
                    default: len = ($urandom_range(7) == 0) ? 8'd0 :
                                   8'($urandom_range(200, 255));
                endcase
                send_run(len, ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
                made++;
            end
        end
    endtask

    initial
    begin
        model        = new();
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        item_valid   = 1'b0;
        op           = OP_NONE;
        run_length   = '0;
        colour_index = '0;
        palette_word = '0;
        seg_stall    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        gap_pct   = 20;
        stall_pct = 50;
        // Nothing comes out before a frame is opened, and an unknown op is ignored.
        send_run(8'd5, 8'd0);
        send_item(OP_NONE, 8'hFF, 8'hFF, 16'hFFFF);
        send_item(OP_PAL, 8'h00, 8'd255, 16'hFFFF);
        send_item(OP_PAL, 8'h00, 8'd1, 16'h0000);
        send_item(OP_PAL, 8'h00, 8'd128, 16'h5A5A);
        send_frame();
        send_run(8'd255, 8'd255);
        send_run(8'd0, 8'd1);
        send_run(8'd1, 8'd0);
        // Box registers written mid-frame only apply once the next frame starts.
        settle();
        set_box(8'd1, 5'd1, 16'h0000, 8'd239, 8'd239);
        send_run(8'd255, 8'd1);
        send_frame();
        send_run(8'd255, 8'd128);
        send_run(8'd3, 8'd0);
        // Zero width or zero bands close the frame at once.
        settle();
        set_box(8'd0, 5'd30, 16'h1234, 8'd0, 8'd0);
        send_frame();
        send_run(8'd10, 8'd0);
        settle();
        set_box(8'd255, 5'd0, 16'hFFFF, 8'd0, 8'd0);
        send_frame();
        send_run(8'd10, 8'd255);
        // A width above the panel limit is clamped, so the band is 1920 pixels.
        settle();
        set_box(8'd255, 5'd1, 16'hA5A5, 8'd17, 8'd200);
        send_frame();
        send_run(8'd255, 8'd0);
        repeat (8) send_run(8'd255, 8'd255);

        settle();
        set_box(8'($urandom_range(1, 12)), 5'($urandom_range(1, 4)), 16'($urandom),
                8'd0, 8'd0);
        gap_pct   = 31;
        stall_pct = 85;
        random_phase(20);

        settle();
        set_box(8'd1, 5'd31, 16'h0000, 8'd239, 8'd239);
        gap_pct   = 85;
        stall_pct = 31;
        random_phase(20);

        settle();
        set_box(8'd255, 5'd1, 16'hFFFF, 8'($urandom_range(239)), 8'($urandom_range(239)));
        gap_pct   = 0;
        stall_pct = 0;
        random_phase(20);

        settle();
        if (model.mismatches == 0)
            $display("rle_palette_band_renderer_top regression: pass");
        else
            $display("rle_palette_band_renderer_top regression: fail");
        $finish;
    end

endmodule
